// ===== src/belt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// belt_pkg
// Shared types, register indexes and the S-box for the belt block cipher.
// ----------------------------------------------------------------------------
package belt_pkg;

    localparam int unsigned ROUNDS = 8;

    typedef struct packed {
        logic        opcode;
        logic [31:0] word_0;
        logic [31:0] word_1;
        logic [31:0] word_2;
        logic [31:0] word_3;
    } in_req_t;

    typedef struct packed {
        logic [31:0] out_0;
        logic [31:0] out_1;
        logic [31:0] out_2;
        logic [31:0] out_3;
    } out_req_t;

    typedef struct packed {
        logic        dec;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } state_t;

    typedef logic [7:0][31:0] key_sched_t;

    localparam logic [2:0] REG_KEY_LOW  = 3'd0;
    localparam logic [2:0] REG_KEY_MID  = 3'd1;
    localparam logic [2:0] REG_KEY_HIGH = 3'd2;
    localparam logic [2:0] REG_KEY_TOP  = 3'd3;
    localparam logic [2:0] REG_KEY_SIZE = 3'd4;

    localparam logic [1:0] KEY_128 = 2'd0;
    localparam logic [1:0] KEY_192 = 2'd1;

    localparam logic [255:0][7:0] SBOX_H = {
        8'h1D,8'hDA,8'h6C,8'h77,8'hEA,8'h10,8'h14,8'h91,8'h75,8'h28,8'h62,8'h3A,8'hB4,8'hD9,8'hEF,8'hD4,
        8'h21,8'h29,8'h23,8'hEB,8'h51,8'hC5,8'h74,8'h69,8'hB3,8'hDF,8'hA8,8'h42,8'h52,8'h46,8'hD7,8'hA2,
        8'h8A,8'hE8,8'hD2,8'h66,8'hBF,8'h50,8'h84,8'hA5,8'h8C,8'hAF,8'h44,8'h15,8'hD0,8'hA4,8'hCD,8'h7E,
        8'hA1,8'h09,8'h4B,8'h19,8'h5F,8'h88,8'h2A,8'hA0,8'h48,8'h9A,8'hFC,8'h43,8'h13,8'h97,8'h32,8'hBE,
        8'h11,8'h55,8'h40,8'h90,8'h34,8'hF9,8'h87,8'h26,8'h2F,8'h64,8'h7D,8'h22,8'hAA,8'h80,8'h20,8'h68,
        8'hF2,8'h0E,8'h4D,8'h5E,8'hC9,8'hFB,8'h45,8'h54,8'h01,8'h41,8'hD1,8'hE5,8'h1C,8'h9B,8'hBD,8'h92,
        8'hF6,8'h8B,8'hA9,8'h03,8'h83,8'hA3,8'hCB,8'h39,8'h37,8'h7A,8'h24,8'hED,8'h16,8'h53,8'h07,8'h06,
        8'h47,8'h96,8'h73,8'h6F,8'hF4,8'h49,8'hDB,8'h2D,8'hA6,8'h0F,8'h0C,8'h8F,8'h2C,8'hE7,8'hDE,8'hE9,
        8'h93,8'hB7,8'h5A,8'h4C,8'h1F,8'h18,8'h1E,8'h59,8'hCF,8'hBC,8'hD3,8'h27,8'h6E,8'hB5,8'h98,8'h3E,
        8'h31,8'h3D,8'hB2,8'h9E,8'h79,8'hA7,8'h4E,8'hDD,8'h6A,8'h30,8'h7C,8'h63,8'h7B,8'h65,8'h3C,8'hF3,
        8'h4F,8'h9C,8'hBB,8'hD5,8'h60,8'hF8,8'hC6,8'hF7,8'hCA,8'h78,8'hE6,8'h9F,8'h38,8'h76,8'hAB,8'hC1,
        8'hF1,8'h8D,8'hEE,8'h95,8'hF0,8'hCC,8'h3F,8'h70,8'hEC,8'h57,8'h82,8'hE2,8'h1A,8'hDC,8'h2B,8'hE1,
        8'h99,8'h7F,8'hE0,8'hD8,8'hAE,8'h05,8'hC4,8'h35,8'hB8,8'h56,8'hC3,8'h33,8'hFF,8'hC0,8'hB0,8'h5C,
        8'h0B,8'h89,8'h6B,8'h71,8'hAD,8'h86,8'h67,8'hFE,8'h81,8'h61,8'hB9,8'h17,8'h12,8'hD6,8'hE3,8'h5B,
        8'h0D,8'hCE,8'hFD,8'h02,8'hC2,8'h72,8'h2E,8'h25,8'hAC,8'hC7,8'hB6,8'h1B,8'h9D,8'hFA,8'h04,8'h85,
        8'hE4,8'h5D,8'h4A,8'h58,8'h8E,8'h00,8'h6D,8'h36,8'h3B,8'hF5,8'h08,8'h0A,8'hC8,8'hBA,8'h94,8'hB1
    };

    function automatic logic [31:0] bswap(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    function automatic logic [31:0] gfun5(input logic [31:0] u);
        logic [31:0] s;
        s = {SBOX_H[u[31:24]], SBOX_H[u[23:16]], SBOX_H[u[15:8]], SBOX_H[u[7:0]]};
        return {s[26:0], s[31:27]};
    endfunction

    function automatic logic [31:0] gfun13(input logic [31:0] u);
        logic [31:0] s;
        s = {SBOX_H[u[31:24]], SBOX_H[u[23:16]], SBOX_H[u[15:8]], SBOX_H[u[7:0]]};
        return {s[18:0], s[31:19]};
    endfunction

    function automatic logic [31:0] gfun21(input logic [31:0] u);
        logic [31:0] s;
        s = {SBOX_H[u[31:24]], SBOX_H[u[23:16]], SBOX_H[u[15:8]], SBOX_H[u[7:0]]};
        return {s[10:0], s[31:11]};
    endfunction

endpackage

// ===== src/belt_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// belt_round
// One cipher round split over three register stages, with stall control.
// ----------------------------------------------------------------------------
module belt_round #(
    parameter int unsigned ROUND = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                stall,
    input  logic                in_valid,
    input  belt_pkg::state_t    in_state,
    input  belt_pkg::key_sched_t kw,
    output logic                out_valid,
    output belt_pkg::state_t    out_state
);

    localparam logic [2:0] BASE_ENC = 3'((7 * ROUND - 7) % 8);
    localparam logic [2:0] BASE_DEC = 3'((7 * (9 - ROUND) - 7) % 8);
    localparam logic [31:0] RND_ENC = 32'(ROUND);
    localparam logic [31:0] RND_DEC = 32'(9 - ROUND);

    logic [2:0] v_reg;
    belt_pkg::state_t s1_reg, s1_next, s2_reg, s2_next, s3_reg, s3_next;

    function automatic logic [31:0] key_at(input logic dec, input logic [2:0] j,
                                            input belt_pkg::key_sched_t k);
        logic [2:0] pos;
        pos = dec ? 3'(BASE_DEC + 3'd6 - j) : 3'(BASE_ENC + j);
        return k[pos];
    endfunction

    always_comb
    begin
        s1_next   = in_state;
        s1_next.b = in_state.b ^ belt_pkg::gfun5(in_state.a + key_at(in_state.dec, 3'd0, kw));
        s1_next.c = in_state.c ^ belt_pkg::gfun21(in_state.d + key_at(in_state.dec, 3'd1, kw));
        s1_next.a = in_state.a - belt_pkg::gfun13(s1_next.b + key_at(in_state.dec, 3'd2, kw));
    end

    always_comb
    begin
        logic [31:0] e;
        s2_next = s1_reg;
        e = belt_pkg::gfun21(s1_reg.b + s1_reg.c + key_at(s1_reg.dec, 3'd3, kw))
            ^ (s1_reg.dec ? RND_DEC : RND_ENC);
        s2_next.b = s1_reg.b + e;
        s2_next.c = s1_reg.c - e;
        s2_next.d = s1_reg.d + belt_pkg::gfun13(s2_next.c + key_at(s1_reg.dec, 3'd4, kw));
    end

    always_comb
    begin
        logic [31:0] b, c;
        b = s2_reg.b ^ belt_pkg::gfun21(s2_reg.a + key_at(s2_reg.dec, 3'd5, kw));
        c = s2_reg.c ^ belt_pkg::gfun5(s2_reg.d + key_at(s2_reg.dec, 3'd6, kw));
        s3_next.dec = s2_reg.dec;
        if (s2_reg.dec)
        begin
            s3_next.a = c;
            s3_next.b = s2_reg.a;
            s3_next.c = s2_reg.d;
            s3_next.d = b;
        end
        else
        begin
            s3_next.a = b;
            s3_next.b = s2_reg.d;
            s3_next.c = s2_reg.a;
            s3_next.d = c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (!stall)
        begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
        end
    end

    assign out_valid = v_reg[2];
    assign out_state = s3_reg;

endmodule

// ===== src/belt_key_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// belt_key_regs
// Key registers and expansion of short keys to eight words.
// ----------------------------------------------------------------------------
module belt_key_regs (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [63:0]          cfg_data,
    output belt_pkg::key_sched_t kw
);

    logic [3:0][63:0] key_reg;
    logic [1:0]       size_reg;
    logic [7:0][31:0] raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg  <= '0;
            size_reg <= 2'd2;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                belt_pkg::REG_KEY_LOW:  key_reg[0] <= cfg_data;
                belt_pkg::REG_KEY_MID:  key_reg[1] <= cfg_data;
                belt_pkg::REG_KEY_HIGH: key_reg[2] <= cfg_data;
                belt_pkg::REG_KEY_TOP:  key_reg[3] <= cfg_data;
                belt_pkg::REG_KEY_SIZE: size_reg   <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign raw = key_reg;

    always_comb
    begin
        kw = raw;
        if (size_reg == belt_pkg::KEY_128)
        begin
            kw[7:4] = raw[3:0];
        end
        else if (size_reg == belt_pkg::KEY_192)
        begin
            kw[6] = raw[0] ^ raw[1] ^ raw[2];
            kw[7] = raw[3] ^ raw[4] ^ raw[5];
        end
    end

endmodule

// ===== src/belt_block_cipher_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// belt_block_cipher_core
// Pipelined belt block cipher, encrypt/decrypt, one block per unstalled cycle.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_ready with an opcode (0 encrypt, 1 decrypt)
// and four block words; results leave on out_valid/out_ready.
// Key registers are written through cfg_we/cfg_index/cfg_data while idle:
// index 0..3 carry key words in pairs, index 4 selects the key size.
// The pipeline is an input register, eight rounds of three stages each, and
// an output register; it takes one block per cycle unless a stall holds it.
// The whole pipeline advances as one; when out_ready is low and the output
// holds a result, every stage holds and in_ready drops, so nothing is lost.
// Reset clears all valid bits, zeroes the key and selects a 256-bit key.
// ----------------------------------------------------------------------------
module belt_block_cipher_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  belt_pkg::in_req_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output belt_pkg::out_req_t out_data,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data
);

    belt_pkg::key_sched_t kw;
    logic                 stall;
    logic                 in_v_reg, out_v_reg;
    belt_pkg::state_t     in_s_reg, in_s_next;
    belt_pkg::out_req_t   out_reg, out_next;
    logic                 v [0:belt_pkg::ROUNDS];
    belt_pkg::state_t     s [0:belt_pkg::ROUNDS];

    belt_key_regs u_keys (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .kw       (kw)
    );

    assign stall    = out_v_reg && !out_ready;
    assign in_ready = !stall;

    always_comb
    begin
        in_s_next.dec = in_data.opcode;
        in_s_next.a   = belt_pkg::bswap(in_data.word_0);
        in_s_next.b   = belt_pkg::bswap(in_data.word_1);
        in_s_next.c   = belt_pkg::bswap(in_data.word_2);
        in_s_next.d   = belt_pkg::bswap(in_data.word_3);
    end

    assign v[0] = in_v_reg;
    assign s[0] = in_s_reg;

    for (genvar r = 0; r < belt_pkg::ROUNDS; r++)
    begin : g_round
        belt_round #(.ROUND(r + 1)) u_round (
            .clk      (clk),
            .rst_n    (rst_n),
            .stall    (stall),
            .in_valid (v[r]),
            .in_state (s[r]),
            .kw       (kw),
            .out_valid(v[r + 1]),
            .out_state(s[r + 1])
        );
    end

    always_comb
    begin
        if (s[belt_pkg::ROUNDS].dec)
        begin
            out_next.out_0 = belt_pkg::bswap(s[belt_pkg::ROUNDS].c);
            out_next.out_1 = belt_pkg::bswap(s[belt_pkg::ROUNDS].a);
            out_next.out_2 = belt_pkg::bswap(s[belt_pkg::ROUNDS].d);
            out_next.out_3 = belt_pkg::bswap(s[belt_pkg::ROUNDS].b);
        end
        else
        begin
            out_next.out_0 = belt_pkg::bswap(s[belt_pkg::ROUNDS].b);
            out_next.out_1 = belt_pkg::bswap(s[belt_pkg::ROUNDS].d);
            out_next.out_2 = belt_pkg::bswap(s[belt_pkg::ROUNDS].a);
            out_next.out_3 = belt_pkg::bswap(s[belt_pkg::ROUNDS].c);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (!stall)
        begin
            in_v_reg  <= in_valid;
            out_v_reg <= v[belt_pkg::ROUNDS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            in_s_reg <= in_s_next;
            out_reg  <= out_next;
        end
    end

    assign out_valid = out_v_reg;
    assign out_data  = out_reg;

endmodule

// ===== src/belt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// belt_checker
// Port-level checks of the cipher core handshakes.
// ----------------------------------------------------------------------------
module belt_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input belt_pkg::out_req_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped or changed while stalled");

    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("request taken during output stall");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

endmodule

bind belt_block_cipher_core belt_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
);

// ===== sim/belt_block_cipher_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// belt_block_cipher_core_tb
// Self-checking bench: drives blocks under random stalls through several key
// settings and compares each result with a built-in belt cipher predictor.
// ----------------------------------------------------------------------------
module belt_block_cipher_core_tb;

    localparam logic OP_ENC = 1'b0;
    localparam logic OP_DEC = 1'b1;
    localparam int PIPE_DEPTH = 26;

    class cipher_scoreboard;
        bit [7:0]  hbox [256];
        bit [63:0] kreg [4];
        bit [1:0]  ksize;
        belt_pkg::out_req_t pending [$];
        int        mismatches;
        int        checked;

        function new();
            bit [7:0] t [256] = '{
                8'hB1,8'h94,8'hBA,8'hC8,8'h0A,8'h08,8'hF5,8'h3B,8'h36,8'h6D,8'h00,8'h8E,8'h58,8'h4A,8'h5D,8'hE4,
                8'h85,8'h04,8'hFA,8'h9D,8'h1B,8'hB6,8'hC7,8'hAC,8'h25,8'h2E,8'h72,8'hC2,8'h02,8'hFD,8'hCE,8'h0D,
                8'h5B,8'hE3,8'hD6,8'h12,8'h17,8'hB9,8'h61,8'h81,8'hFE,8'h67,8'h86,8'hAD,8'h71,8'h6B,8'h89,8'h0B,
                8'h5C,8'hB0,8'hC0,8'hFF,8'h33,8'hC3,8'h56,8'hB8,8'h35,8'hC4,8'h05,8'hAE,8'hD8,8'hE0,8'h7F,8'h99,
                8'hE1,8'h2B,8'hDC,8'h1A,8'hE2,8'h82,8'h57,8'hEC,8'h70,8'h3F,8'hCC,8'hF0,8'h95,8'hEE,8'h8D,8'hF1,
                8'hC1,8'hAB,8'h76,8'h38,8'h9F,8'hE6,8'h78,8'hCA,8'hF7,8'hC6,8'hF8,8'h60,8'hD5,8'hBB,8'h9C,8'h4F,
                8'hF3,8'h3C,8'h65,8'h7B,8'h63,8'h7C,8'h30,8'h6A,8'hDD,8'h4E,8'hA7,8'h79,8'h9E,8'hB2,8'h3D,8'h31,
                8'h3E,8'h98,8'hB5,8'h6E,8'h27,8'hD3,8'hBC,8'hCF,8'h59,8'h1E,8'h18,8'h1F,8'h4C,8'h5A,8'hB7,8'h93,
                8'hE9,8'hDE,8'hE7,8'h2C,8'h8F,8'h0C,8'h0F,8'hA6,8'h2D,8'hDB,8'h49,8'hF4,8'h6F,8'h73,8'h96,8'h47,
                8'h06,8'h07,8'h53,8'h16,8'hED,8'h24,8'h7A,8'h37,8'h39,8'hCB,8'hA3,8'h83,8'h03,8'hA9,8'h8B,8'hF6,
                8'h92,8'hBD,8'h9B,8'h1C,8'hE5,8'hD1,8'h41,8'h01,8'h54,8'h45,8'hFB,8'hC9,8'h5E,8'h4D,8'h0E,8'hF2,
                8'h68,8'h20,8'h80,8'hAA,8'h22,8'h7D,8'h64,8'h2F,8'h26,8'h87,8'hF9,8'h34,8'h90,8'h40,8'h55,8'h11,
                8'hBE,8'h32,8'h97,8'h13,8'h43,8'hFC,8'h9A,8'h48,8'hA0,8'h2A,8'h88,8'h5F,8'h19,8'h4B,8'h09,8'hA1,
                8'h7E,8'hCD,8'hA4,8'hD0,8'h15,8'h44,8'hAF,8'h8C,8'hA5,8'h84,8'h50,8'hBF,8'h66,8'hD2,8'hE8,8'h8A,
                8'hA2,8'hD7,8'h46,8'h52,8'h42,8'hA8,8'hDF,8'hB3,8'h69,8'h74,8'hC5,8'h51,8'hEB,8'h23,8'h29,8'h21,
                8'hD4,8'hEF,8'hD9,8'hB4,8'h3A,8'h62,8'h28,8'h75,8'h91,8'h14,8'h10,8'hEA,8'h77,8'h6C,8'hDA,8'h1D};
            hbox = t;
            foreach (kreg[i]) kreg[i] = '0;
            ksize = 2'd2;
            mismatches = 0;
            checked = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [63:0] val);
            case (idx)
                belt_pkg::REG_KEY_LOW:  kreg[0] = val;
                belt_pkg::REG_KEY_MID:  kreg[1] = val;
                belt_pkg::REG_KEY_HIGH: kreg[2] = val;
                belt_pkg::REG_KEY_TOP:  kreg[3] = val;
                belt_pkg::REG_KEY_SIZE: ksize = val[1:0];
                default: ;
            endcase
        endfunction

        function bit [31:0] swap_bytes(bit [31:0] v);
            return {v[7:0], v[15:8], v[23:16], v[31:24]};
        endfunction

        function bit [31:0] g_rot(bit [31:0] u, int r);
            bit [31:0] s;
            s = {hbox[u[31:24]], hbox[u[23:16]], hbox[u[15:8]], hbox[u[7:0]]};
            return (s << r) | (s >> (32 - r));
        endfunction

        function belt_pkg::out_req_t cipher_block(belt_pkg::in_req_t req);
            bit [31:0] kw [8];
            bit [31:0] k [7];
            bit [31:0] a, b, c, d, e, t;
            int rnd, base;
            belt_pkg::out_req_t res;
            for (int i = 0; i < 4; i++)
            begin
                kw[2*i]   = kreg[i][31:0];
                kw[2*i+1] = kreg[i][63:32];
            end
            if (ksize == belt_pkg::KEY_128)
            begin
                for (int i = 0; i < 4; i++) kw[i+4] = kw[i];
            end
            else if (ksize == belt_pkg::KEY_192)
            begin
                kw[6] = kw[0] ^ kw[1] ^ kw[2];
                kw[7] = kw[3] ^ kw[4] ^ kw[5];
            end
            a = swap_bytes(req.word_0);
            b = swap_bytes(req.word_1);
            c = swap_bytes(req.word_2);
            d = swap_bytes(req.word_3);
            for (int i = 1; i <= 8; i++)
            begin
                rnd = (req.opcode == OP_DEC) ? 9 - i : i;
                base = 7 * rnd - 7;
                for (int j = 0; j < 7; j++)
                    k[j] = kw[((req.opcode == OP_DEC) ? base + 6 - j : base + j) % 8];
                b ^= g_rot(a + k[0], 5);
                c ^= g_rot(d + k[1], 21);
                a -= g_rot(b + k[2], 13);
                e = g_rot(b + c + k[3], 21) ^ rnd;
                b += e;
                c -= e;
                d += g_rot(c + k[4], 13);
                b ^= g_rot(a + k[5], 21);
                c ^= g_rot(d + k[6], 5);
                t = a; a = b; b = t;
                t = c; c = d; d = t;
                if (req.opcode == OP_DEC)
                begin
                    t = a; a = d; d = t;
                end
                else
                begin
                    t = b; b = c; c = t;
                end
            end
            if (req.opcode == OP_DEC)
                res = '{swap_bytes(c), swap_bytes(a), swap_bytes(d), swap_bytes(b)};
            else
                res = '{swap_bytes(b), swap_bytes(d), swap_bytes(a), swap_bytes(c)};
            return res;
        endfunction

        function void note_request(belt_pkg::in_req_t req);
            pending.push_back(cipher_block(req));
        endfunction

        function void check_result(belt_pkg::out_req_t got);
            belt_pkg::out_req_t exp_res;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result %h", got);
                return;
            end
            exp_res = pending.pop_front();
            if (got.out_0 !== exp_res.out_0 || got.out_1 !== exp_res.out_1 ||
                got.out_2 !== exp_res.out_2 || got.out_3 !== exp_res.out_3)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d expected %h got %h", checked, exp_res, got);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    belt_pkg::in_req_t  in_data;
    logic               out_valid;
    logic               out_ready;
    belt_pkg::out_req_t out_data;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [63:0]        cfg_data;

    cipher_scoreboard blocks_sb;
    bit quiet_phase;
    int sent;

    belt_block_cipher_core DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("belt_block_cipher_core test failed");
        $finish;
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        blocks_sb.set_reg(idx, val);
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_key(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                            logic [63:0] k3, logic [1:0] sz);
        write_reg(belt_pkg::REG_KEY_LOW, k0);
        write_reg(belt_pkg::REG_KEY_MID, k1);
        write_reg(belt_pkg::REG_KEY_HIGH, k2);
        write_reg(belt_pkg::REG_KEY_TOP, k3);
        write_reg(belt_pkg::REG_KEY_SIZE, {62'd0, sz});
    endtask

    task automatic send_block(logic op, logic [31:0] w0, logic [31:0] w1,
                              logic [31:0] w2, logic [31:0] w3);
        belt_pkg::in_req_t req;
        if (!quiet_phase && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        req = '{op, w0, w1, w2, w3};
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        blocks_sb.note_request(req);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (blocks_sb.pending.size() != 0) @(posedge clk);
        repeat (PIPE_DEPTH + 4) @(posedge clk);
    endtask

    task automatic random_blocks(int n);
        for (int i = 0; i < n; i++)
        begin
            logic op;
            op = $urandom_range(0, 1) ? OP_DEC : OP_ENC;
            send_block(op, rand_word(), rand_word(), rand_word(), rand_word());
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            blocks_sb.check_result(out_data);
    end

    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall > 0)
            begin
                stall--;
                out_ready <= 1'b0;
            end
            else if (!quiet_phase && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(1, 5) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        blocks_sb = new();
        quiet_phase = 1'b0;
        sent = 0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset key, extremes, both operations
        send_block(OP_ENC, 32'h0, 32'h0, 32'h0, 32'h0);
        send_block(OP_DEC, 32'h0, 32'h0, 32'h0, 32'h0);
        send_block(OP_ENC, '1, '1, '1, '1);
        send_block(OP_DEC, '1, '1, '1, '1);
        drain();
        load_key('1, '1, '1, '1, 2'd2);
        send_block(OP_ENC, 32'h0, '1, 32'h0, '1);
        send_block(OP_DEC, '1, 32'h0, '1, 32'h0);
        drain();
        load_key(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
                 64'hDEAD_BEEF_0000_FFFF, 64'h5555_AAAA_3333_CCCC, belt_pkg::KEY_128);
        send_block(OP_ENC, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
        send_block(OP_DEC, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
        drain();
        write_reg(belt_pkg::REG_KEY_SIZE, {62'd0, belt_pkg::KEY_192});
        send_block(OP_ENC, 32'h8000_0001, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF);
        send_block(OP_DEC, 32'h8000_0001, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF);
        drain();
        // unused size code behaves as a full key; out-of-range index is ignored
        write_reg(belt_pkg::REG_KEY_SIZE, 64'd3);
        write_reg(3'd7, '1);
        write_reg(3'd5, 64'h1);
        send_block(OP_ENC, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'hFFFF_0000, 32'h0000_FFFF);
        send_block(OP_DEC, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'hFFFF_0000, 32'h0000_FFFF);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            load_key({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, 2'($urandom_range(0, 3)));
            if (ph == 7)
                quiet_phase = 1'b1;
            random_blocks(118);
            drain();
        end

        $display("Sent %0d blocks over several key sizes, %0d results checked.",
                 sent, blocks_sb.checked);
        if (blocks_sb.mismatches == 0)
            $display("belt_block_cipher_core test passed");
        else
        begin
            $display("%0d mismatches", blocks_sb.mismatches);
            $display("belt_block_cipher_core test failed");
        end
        $finish;
    end

endmodule
